@@ rtl/core/psd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, command and status types for the pairwise squared
// distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int MAX_TRAIN  = 32;
   localparam int MAX_DIM    = 64;
   localparam int ELEM_WIDTH = 16;

   localparam int TRAIN_IDX_W  = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int DIM_IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int STORE_DEPTH  = MAX_TRAIN * MAX_DIM;
   localparam int STORE_ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int DIM_REG_W   = 7;
   localparam int COUNT_REG_W = 6;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam int DIFF_W      = ELEM_WIDTH + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int SUM_W       = 39;
   localparam int DIST_W      = 38;
   localparam int TEST_IDX_W  = 16;
   localparam int OUT_TRAIN_W = 5;

   localparam logic CMD_TRAIN = 1'b0;
   localparam logic CMD_TEST  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_IN_USE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIN_COUNT = 1'b1;

   typedef struct packed {
      logic                   store_we;
      logic [TRAIN_IDX_W-1:0] load_vp;
      logic [DIM_IDX_W-1:0]   load_ep;
      logic                   latch;
      logic                   first;
      logic                   issue;
      logic                   emit_rd;
      logic                   out_load;
      logic [TRAIN_IDX_W-1:0] idx;
      logic [DIM_IDX_W-1:0]   test_ep;
      logic                   out_last;
      logic [TEST_IDX_W-1:0]  out_test_index;
   } dp_cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic out_free;
   } dp_stat_type;

   function automatic logic [STORE_ADDR_W-1:0] store_addr(
      input logic [TRAIN_IDX_W-1:0] vp,
      input logic [DIM_IDX_W-1:0]   ep
   );
      logic [STORE_ADDR_W-1:0] base;
      base = STORE_ADDR_W'(vp) * STORE_ADDR_W'(MAX_DIM);
      return base + STORE_ADDR_W'(ep);
   endfunction

endpackage

@@ rtl/core/pairwise_squared_distance_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_squared_distance_top
// Squared Euclidean distances between stored training vectors and streamed
// test vectors.
// ----------------------------------------------------------------------------
// usage
//   req channel: command 0 loads one training element, command 1 streams one
//   test element. csr port sets dim_in_use (index 0) and train_count (index 1);
//   the user writes them only while the block is idle (not enforced).
//   rsp channel: after the final element of a test vector, one distance per
//   training vector in training order, last set on the final one.
// timing
//   training element: taken back to back while the block is idle.
//   test element: the sweep reads and rewrites one partial sum per cycle
//   through a three-stage read / square / accumulate pipeline; new
//   elements are stalled until it drains.
//   final test element: each result takes a memory read, then a load of the
//   result register; emission starts once the sweep drains.
// reset
//   clears positions, test index and partial sums; dim_in_use 1, train_count
//   32. training store contents stay undefined until loaded.
// stall
//   a stalled result holds in the result register; emission waits for it,
//   and after the last result is loaded new elements are taken at once.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_top
   import psd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [ELEM_WIDTH-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIST_W-1:0]             rsp_distance,
   output logic [OUT_TRAIN_W-1:0]        rsp_train_index,
   output logic [TEST_IDX_W-1:0]         rsp_test_index,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   psd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat)
   );

   psd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance    (rsp_distance),
      .rsp_train_index (rsp_train_index),
      .rsp_test_index  (rsp_test_index),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/core/psd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_datapath
// Training store, partial sum memory, difference-square-accumulate pipeline
// and result register.
// ----------------------------------------------------------------------------
module psd_datapath
   import psd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   output dp_stat_type                    stat,
   input  logic signed [ELEM_WIDTH-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [DIST_W-1:0]              rsp_distance,
   output logic [OUT_TRAIN_W-1:0]         rsp_train_index,
   output logic [TEST_IDX_W-1:0]          rsp_test_index,
   output logic                           rsp_last
);

   logic signed [ELEM_WIDTH-1:0] train_store_ff [STORE_DEPTH];
   logic [SUM_W-1:0]             sums_ff [MAX_TRAIN];
   logic [MAX_TRAIN-1:0]         sum_vld_ff;

   logic signed [ELEM_WIDTH-1:0] val_ff;
   logic                         first_ff;

   logic signed [ELEM_WIDTH-1:0] store_rd_ff;
   logic [SUM_W-1:0]             sum_rd_ff;
   logic                         sum_vld_rd_ff;
   logic                         s1_valid_ff;
   logic [TRAIN_IDX_W-1:0]       s1_idx_ff;

   logic [SQ_W-1:0]              s2_sq_ff;
   logic [SUM_W-1:0]             s2_sum_ff;
   logic                         s2_valid_ff;
   logic [TRAIN_IDX_W-1:0]       s2_idx_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [DIST_W-1:0]            rsp_distance_ff;
   logic [OUT_TRAIN_W-1:0]       rsp_train_index_ff;
   logic [TEST_IDX_W-1:0]        rsp_test_index_ff;
   logic                         rsp_last_ff;

   logic signed [DIFF_W-1:0]     diff;
   logic signed [SQ_W-1:0]       sq;
   logic [SUM_W-1:0]             sum_old;
   logic [SUM_W-1:0]             sum_new;
   logic                         rsp_xfer;

   // training store
   always_ff @(posedge clock) begin
      if (cmd.store_we) begin
         train_store_ff[store_addr(cmd.load_vp, cmd.load_ep)] <= req_value;
      end
      if (cmd.issue) begin
         store_rd_ff <= train_store_ff[store_addr(cmd.idx, cmd.test_ep)];
      end
   end

   // partial sum memory
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         sums_ff[s2_idx_ff] <= sum_new;
      end
      if (cmd.issue || cmd.emit_rd) begin
         sum_rd_ff <= sums_ff[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff    <= '0;
         sum_vld_rd_ff <= 1'b0;
      end else begin
         if (s2_valid_ff) begin
            sum_vld_ff[s2_idx_ff] <= 1'b1;
         end
         if (cmd.issue || cmd.emit_rd) begin
            sum_vld_rd_ff <= sum_vld_ff[cmd.idx];
         end
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         val_ff   <= req_value;
         first_ff <= cmd.first;
      end
   end

   // difference and square
   assign diff    = {store_rd_ff[ELEM_WIDTH-1], store_rd_ff} - {val_ff[ELEM_WIDTH-1], val_ff};
   assign sq      = diff * diff;
   assign sum_old = sum_vld_rd_ff ? sum_rd_ff : '0;
   assign sum_new = first_ff ? SUM_W'(s2_sq_ff) : (s2_sum_ff + SUM_W'(s2_sq_ff));

   always_ff @(posedge clock) begin
      s1_idx_ff <= cmd.idx;
      s2_idx_ff <= s1_idx_ff;
      s2_sq_ff  <= unsigned'(sq);
      s2_sum_ff <= sum_old;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // result register
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_distance_ff    <= sum_old[DIST_W-1:0];
         rsp_train_index_ff <= OUT_TRAIN_W'(cmd.idx);
         rsp_test_index_ff  <= cmd.out_test_index;
         rsp_last_ff        <= cmd.out_last;
      end
   end

   assign stat.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_train_index = rsp_train_index_ff;
   assign rsp_test_index  = rsp_test_index_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ rtl/core/psd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: configuration registers, load and test positions, sweep over
// the training vectors and result emission.
// ----------------------------------------------------------------------------
module psd_ctrl
   import psd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output dp_cmd_type             cmd,
   input  dp_stat_type            stat
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SWEEP   = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EMIT    = 3'd3;
   localparam logic [2:0] ST_EMIT_LD = 3'd4;

   logic [2:0]             state_ff,  state_in;
   logic [DIM_REG_W-1:0]   dim_ff,    dim_in;
   logic [COUNT_REG_W-1:0] cnt_ff,    cnt_in;
   logic [TRAIN_IDX_W-1:0] lvp_ff,    lvp_in;
   logic [DIM_IDX_W-1:0]   lep_ff,    lep_in;
   logic [DIM_IDX_W-1:0]   tep_ff,    tep_in;
   logic [TEST_IDX_W-1:0]  tvi_ff,    tvi_in;
   logic [TRAIN_IDX_W-1:0] idx_ff,    idx_in;
   logic                   final_ff,  final_in;

   logic [DIM_REG_W-1:0]   dim_eff;
   logic [COUNT_REG_W-1:0] cnt_eff;
   logic                   req_xfer;
   logic                   idx_last;

   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DIM_REG_W'(1);
      end else if (dim_ff > DIM_REG_W'(MAX_DIM)) begin
         dim_eff = DIM_REG_W'(MAX_DIM);
      end else begin
         dim_eff = dim_ff;
      end
      if (cnt_ff == '0) begin
         cnt_eff = COUNT_REG_W'(1);
      end else if (cnt_ff > COUNT_REG_W'(MAX_TRAIN)) begin
         cnt_eff = COUNT_REG_W'(MAX_TRAIN);
      end else begin
         cnt_eff = cnt_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign idx_last  = (COUNT_REG_W'(idx_ff) + COUNT_REG_W'(1)) >= cnt_eff;

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      cnt_in   = cnt_ff;
      lvp_in   = lvp_ff;
      lep_in   = lep_ff;
      tep_in   = tep_ff;
      tvi_in   = tvi_ff;
      idx_in   = idx_ff;
      final_in = final_ff;

      cmd                = '0;
      cmd.load_vp        = lvp_ff;
      cmd.load_ep        = lep_ff;
      cmd.first          = (tep_ff == '0);
      cmd.idx            = idx_ff;
      cmd.test_ep        = tep_ff;
      cmd.out_last       = idx_last;
      cmd.out_test_index = tvi_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIM_IN_USE:  dim_in = csr_write_data[DIM_REG_W-1:0];
            CSR_TRAIN_COUNT: cnt_in = csr_write_data[COUNT_REG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_command == CMD_TRAIN) begin
                  cmd.store_we = 1'b1;
                  tep_in       = '0;
                  if ((DIM_REG_W'(lep_ff) + DIM_REG_W'(1)) >= dim_eff) begin
                     lep_in = '0;
                     if ((COUNT_REG_W'(lvp_ff) + COUNT_REG_W'(1)) >= cnt_eff) begin
                        lvp_in = '0;
                     end else begin
                        lvp_in = lvp_ff + TRAIN_IDX_W'(1);
                     end
                  end else begin
                     lep_in = lep_ff + DIM_IDX_W'(1);
                  end
               end else begin
                  cmd.latch = 1'b1;
                  final_in  = (DIM_REG_W'(tep_ff) + DIM_REG_W'(1)) >= dim_eff;
                  idx_in    = '0;
                  state_in  = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + TRAIN_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               if (final_ff) begin
                  tep_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  tep_in   = tep_ff + DIM_IDX_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_rd = 1'b1;
               state_in    = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            cmd.out_load = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               tvi_in   = tvi_ff + TEST_IDX_W'(1);
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + TRAIN_IDX_W'(1);
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dim_ff   <= DIM_REG_W'(1);
         cnt_ff   <= COUNT_REG_W'(MAX_TRAIN);
         lvp_ff   <= '0;
         lep_ff   <= '0;
         tep_ff   <= '0;
         tvi_ff   <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
         cnt_ff   <= cnt_in;
         lvp_ff   <= lvp_in;
         lep_ff   <= lep_in;
         tep_ff   <= tep_in;
         tvi_ff   <= tvi_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
      end
   end

endmodule

@@ tb/pairwise_squared_distance_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_squared_distance_top_tb
// Self-checking bench for the pairwise squared distance block. A queue of
// training and test elements feeds a clocked driver; every accepted element
// steps a local distance model whose predicted distances are compared with
// each result transfer. A planning copy of the model keeps the stimulus from
// ever reading a training entry that was never loaded. Phases change the
// vector size and training count (extremes and out-of-range values too) and
// the idle and stall patterns, including one long result hold-off.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_top_tb
   import psd_pkg::*;
();

   localparam int MODEL_PLAN         = 0;
   localparam int MODEL_LIVE         = 1;
   localparam int SETTLE_CYCLES      = 150;
   localparam int LONG_HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEM_TARGET = 270;
   localparam int REPORT_LIMIT       = 10;

   localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = 16'sh7fff;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic                         command;
      logic signed [ELEM_WIDTH-1:0] value;
   } vec_elem_type;

   typedef struct packed {
      logic [DIST_W-1:0]      distance;
      logic [OUT_TRAIN_W-1:0] train_index;
      logic [TEST_IDX_W-1:0]  test_index;
      logic                   last;
   } dist_result_type;

   logic                         clock;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic                         req_command      = 1'b0;
   logic signed [ELEM_WIDTH-1:0] req_value        = '0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [DIST_W-1:0]            rsp_distance;
   logic [OUT_TRAIN_W-1:0]       rsp_train_index;
   logic [TEST_IDX_W-1:0]        rsp_test_index;
   logic                         rsp_last;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index        = '0;
   logic [CSR_DATA_W-1:0]        csr_write_data   = '0;

   // distance model, one copy for planning stimulus and one stepped on transfers
   bit signed [ELEM_WIDTH-1:0] train_mem [2][STORE_DEPTH];
   bit                         loaded    [2][STORE_DEPTH];
   bit [SUM_W-1:0]             sums      [2][MAX_TRAIN];
   int unsigned                load_vp   [2];
   int unsigned                load_ep   [2];
   int unsigned                test_ep   [2];
   bit [TEST_IDX_W-1:0]        test_num  [2];
   bit [DIM_REG_W-1:0]         dim_reg   [2] = '{1, 1};
   bit [COUNT_REG_W-1:0]       count_reg [2] = '{MAX_TRAIN, MAX_TRAIN};

   vec_elem_type    elements_to_send [$];
   dist_result_type expected_dists [$];
   vec_elem_type    next_elem;
   dist_result_type exp_dist;
   int unsigned  items_open     = 0;
   int unsigned  queued_total   = 0;
   int unsigned  directed_total = 0;
   int unsigned  fail_count     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   bit           hold_arm       = 1'b0;
   bit           hold_used      = 1'b0;
   int unsigned  hold_left      = 0;

   pairwise_squared_distance_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance),
      .rsp_train_index  (rsp_train_index),
      .rsp_test_index   (rsp_test_index),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned active_dim(int s);
      if (dim_reg[s] == 0) return 1;
      if (dim_reg[s] > MAX_DIM) return MAX_DIM;
      return dim_reg[s];
   endfunction

   function automatic int unsigned active_count(int s);
      if (count_reg[s] == 0) return 1;
      if (count_reg[s] > MAX_TRAIN) return MAX_TRAIN;
      return count_reg[s];
   endfunction

   function automatic void step_distance_model(int s, logic cmd,
                                               logic signed [ELEM_WIDTH-1:0] v);
      int unsigned  dim;
      int unsigned  cnt;
      int unsigned  vp;
      int unsigned  ep;
      longint       diff;
      bit [SUM_W-1:0] sq;
      bit           first;
      dist_result_type r;
      dim = active_dim(s);
      cnt = active_count(s);
      if (cmd == CMD_TRAIN) begin
         vp = load_vp[s] % MAX_TRAIN;
         ep = load_ep[s] % MAX_DIM;
         train_mem[s][vp * MAX_DIM + ep] = v;
         loaded[s][vp * MAX_DIM + ep] = 1'b1;
         test_ep[s] = 0;
         if (load_ep[s] + 1 >= dim) begin
            load_ep[s] = 0;
            load_vp[s] = (vp + 1 >= cnt) ? 0 : vp + 1;
         end else begin
            load_ep[s] = load_ep[s] + 1;
         end
         return;
      end
      ep = test_ep[s] % MAX_DIM;
      first = (test_ep[s] == 0);
      for (int t = 0; t < cnt; t++) begin
         diff = longint'(train_mem[s][t * MAX_DIM + ep]) - longint'(v);
         sq = SUM_W'(diff * diff);
         sums[s][t] = first ? sq : sums[s][t] + sq;
      end
      if (test_ep[s] + 1 < dim) begin
         test_ep[s] = test_ep[s] + 1;
         return;
      end
      if (s == MODEL_LIVE) begin
         for (int t = 0; t < cnt; t++) begin
            r.distance    = sums[s][t][DIST_W-1:0];
            r.train_index = OUT_TRAIN_W'(t);
            r.test_index  = test_num[s];
            r.last        = (t + 1 == cnt);
            expected_dists.push_back(r);
         end
      end
      test_ep[s] = 0;
      test_num[s] = test_num[s] + 1'b1;
   endfunction

   function automatic bit reads_unloaded(int s);
      int unsigned ep;
      ep = test_ep[s] % MAX_DIM;
      for (int t = 0; t < active_count(s); t++)
         if (!loaded[s][t * MAX_DIM + ep]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit store_covered(int s);
      for (int t = 0; t < active_count(s); t++)
         for (int e = 0; e < active_dim(s); e++)
            if (!loaded[s][t * MAX_DIM + e]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic signed [ELEM_WIDTH-1:0] pick_value(int extreme);
      if ($urandom_range(0, 99) < extreme) begin
         case ($urandom_range(0, 3))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      return ELEM_WIDTH'($urandom);
   endfunction

   function automatic void queue_element(logic cmd, logic signed [ELEM_WIDTH-1:0] v);
      vec_elem_type e;
      e.command = cmd;
      e.value   = v;
      elements_to_send.push_back(e);
      items_open++;
      queued_total++;
      step_distance_model(MODEL_PLAN, cmd, v);
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      for (int s = 0; s < 2; s++) begin
         if (idx == CSR_DIM_IN_USE) dim_reg[s] = data;
         else count_reg[s] = data[COUNT_REG_W-1:0];
      end
   endtask

   task automatic wait_for_idle();
      while (items_open != 0 || expected_dists.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] dim_w,
                            input logic [CSR_DATA_W-1:0] cnt_w,
                            input idle_mode_type mode, input int n_random,
                            input int extreme);
      int unsigned reload;
      int          noise;
      logic signed [ELEM_WIDTH-1:0] v;
      wait_for_idle();
      write_csr(CSR_DIM_IN_USE, dim_w);
      write_csr(CSR_TRAIN_COUNT, cnt_w);
      send_idle_pct  = (mode == IDLE_SEND) ? 88 : (mode == IDLE_BOTH) ? 8 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 88 : (mode == IDLE_BOTH) ? 8 : 0;
      reload = active_count(MODEL_PLAN) * active_dim(MODEL_PLAN);
      if (reload > 64) reload = 0;
      for (int i = 0; i < reload; i++) queue_element(CMD_TRAIN, pick_value(extreme));
      while (!store_covered(MODEL_PLAN)) queue_element(CMD_TRAIN, pick_value(extreme));
      // stray training elements break test vectors only where vectors are short
      noise = (active_dim(MODEL_PLAN) > 8) ? 0 : 8;
      for (int i = 0; i < n_random; i++) begin
         v = pick_value(extreme);
         if ($urandom_range(0, 99) < noise || reads_unloaded(MODEL_PLAN))
            queue_element(CMD_TRAIN, v);
         else
            queue_element(CMD_TEST, v);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_distance_model(MODEL_LIVE, req_command, req_value);
            items_open--;
         end
         if (!req_valid || !req_stall) begin
            if (elements_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_elem = elements_to_send.pop_front();
               req_valid   <= 1'b1;
               req_command <= next_elem.command;
               req_value   <= next_elem.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_used) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dists.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected result transfer: dist %0d train %0d test %0d last %0d",
                        rsp_distance, rsp_train_index, rsp_test_index, rsp_last);
            fail_count++;
         end else begin
            exp_dist = expected_dists.pop_front();
            if (rsp_distance !== exp_dist.distance ||
                rsp_train_index !== exp_dist.train_index ||
                rsp_test_index !== exp_dist.test_index ||
                rsp_last !== exp_dist.last) begin
               if (fail_count < REPORT_LIMIT)
                  $display("mismatch: exp dist %0d train %0d test %0d last %0d,",
                           exp_dist.distance, exp_dist.train_index, exp_dist.test_index,
                           exp_dist.last,
                           " got dist %0d train %0d test %0d last %0d",
                           rsp_distance, rsp_train_index, rsp_test_index, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_for_idle();

      // directed: two vectors of two elements at the value extremes
      write_csr(CSR_DIM_IN_USE, 7'd2);
      write_csr(CSR_TRAIN_COUNT, 7'd2);
      queue_element(CMD_TRAIN, ELEM_MIN);
      queue_element(CMD_TRAIN, ELEM_MAX);
      queue_element(CMD_TRAIN, ELEM_MAX);
      queue_element(CMD_TRAIN, ELEM_MIN);
      queue_element(CMD_TEST, ELEM_MAX);
      queue_element(CMD_TEST, ELEM_MIN);
      queue_element(CMD_TEST, ELEM_MIN);
      queue_element(CMD_TEST, ELEM_MAX);
      queue_element(CMD_TEST, '0);
      queue_element(CMD_TEST, '1);
      // partial test vector dropped by a training element
      queue_element(CMD_TEST, 16'sd5);
      queue_element(CMD_TRAIN, '0);
      queue_element(CMD_TEST, '1);
      queue_element(CMD_TEST, 16'sd1);
      queue_element(CMD_TEST, '0);
      // shrink the vector while a test vector is half done
      wait_for_idle();
      write_csr(CSR_DIM_IN_USE, 7'd1);
      queue_element(CMD_TEST, 16'sd7);
      queue_element(CMD_TRAIN, 16'sd9);
      directed_total = queued_total;

      run_phase(7'd3, 7'd4, IDLE_NONE, 16, 10);
      run_phase(7'd1, 7'd63, IDLE_RECV, 8, 10);
      hold_arm = 1'b1;
      run_phase(7'd4, 7'd6, IDLE_NONE, 16, 10);
      run_phase(7'd0, 7'd0, IDLE_SEND, 8, 10);
      run_phase(7'd127, 7'd1, IDLE_BOTH, 64, 50);
      run_phase(7'd2, 7'd8, IDLE_SEND, 12, 10);
      while (queued_total - directed_total < RANDOM_ITEM_TARGET)
         run_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 12)),
                   idle_mode_type'($urandom_range(0, 3)), 12, 10);

      wait_for_idle();
      if (fail_count == 0 && expected_dists.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
